// File: sv/fspa_pkg.sv
`default_nettype none
package fspa_pkg;

	localparam int CMD_W       = 3;
	localparam int CAP_W       = 11;
	localparam int OBJ_W       = 16;
	localparam int STRIDE_W    = 17;
	localparam int OFF_W       = 28;
	localparam int NODE_W      = 27;
	localparam int OUT_W       = 27;
	localparam int PROD_W      = 28;
	localparam int DIV_STEPS   = 27;
	localparam int DIV_CNT_W   = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int REG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CMD_W-1:0] CMD_INIT      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DISABLE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FREE      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INDEX_OF  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_OFFSET_OF = 3'd5;

	localparam logic [REG_IDX_W-1:0] REG_CAPACITY     = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_OBJECT_BYTES = 1'b1;

	typedef enum logic [2:0] {
		OP_INIT      = 3'd0,
		OP_DISABLE   = 3'd1,
		OP_ALLOC     = 3'd2,
		OP_FREE      = 3'd3,
		OP_INDEX_OF  = 3'd4,
		OP_OFFSET_OF = 3'd5,
		OP_NOP       = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_INVALID_INIT = 3'd1,
		ST_ALREADY_INIT = 3'd2,
		ST_NOT_INIT     = 3'd3,
		ST_EMPTY        = 3'd4,
		ST_BAD_OFFSET   = 3'd5,
		ST_RANGE        = 3'd6,
		ST_NOT_ALLOC    = 3'd7
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_RD   = 5'b00100,
		S_MUL  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	typedef struct packed {
		op_t               op;
		logic              node_neg;
		logic [NODE_W-1:0] node;
		logic [CAP_W-1:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [CAP_W-1:0] capacity;
		logic [OBJ_W-1:0] object_bytes;
	} cfg_t;

endpackage
`default_nettype wire

// File: sv/fspa_front.sv
`default_nettype none
module fspa_front #(
	parameter int HEADER_BYTES = 24
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [fspa_pkg::CMD_W-1:0]    command,
	input  wire  signed [fspa_pkg::OFF_W-1:0] data_offset,
	input  wire  [fspa_pkg::CAP_W-1:0]    slot_index,
	output logic                          push_valid,
	input  wire                           push_ready,
	output fspa_pkg::req_t                push_req
);

	logic           valid_s1;
	fspa_pkg::req_t req_s1;
	fspa_pkg::req_t req_d;
	logic [fspa_pkg::OFF_W:0] node_full;

	// offset minus header, one bit wider so the sign survives
	always_comb begin
		node_full = {data_offset[fspa_pkg::OFF_W-1], data_offset}
			- (fspa_pkg::OFF_W+1)'(HEADER_BYTES);
		case (command)
			fspa_pkg::CMD_INIT:      req_d.op = fspa_pkg::OP_INIT;
			fspa_pkg::CMD_DISABLE:   req_d.op = fspa_pkg::OP_DISABLE;
			fspa_pkg::CMD_ALLOC:     req_d.op = fspa_pkg::OP_ALLOC;
			fspa_pkg::CMD_FREE:      req_d.op = fspa_pkg::OP_FREE;
			fspa_pkg::CMD_INDEX_OF:  req_d.op = fspa_pkg::OP_INDEX_OF;
			fspa_pkg::CMD_OFFSET_OF: req_d.op = fspa_pkg::OP_OFFSET_OF;
			default:                 req_d.op = fspa_pkg::OP_NOP;
		endcase
		req_d.node_neg   = node_full[fspa_pkg::OFF_W];
		req_d.node       = node_full[fspa_pkg::NODE_W-1:0];
		req_d.slot_index = slot_index;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_req   = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= req_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/fspa_queue.sv
`default_nettype none
module fspa_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	output logic                 push_ready,
	input  fspa_pkg::req_t       push_req,
	output logic                 pop_valid,
	input  wire                  pop_ready,
	output fspa_pkg::req_t       pop_req
);

	fspa_pkg::req_t                entries_q [fspa_pkg::QUEUE_DEPTH];
	logic [fspa_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [fspa_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [fspa_pkg::QPTR_W:0]     count_q;
	logic                          push;
	logic                          pop;

	assign push_ready = count_q != (fspa_pkg::QPTR_W+1)'(fspa_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_req    = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_req;
		end
	end

endmodule
`default_nettype wire

// File: sv/fspa_div.sv
`default_nettype none
module fspa_div (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire  [fspa_pkg::NODE_W-1:0]     dividend,
	input  wire  [fspa_pkg::STRIDE_W-1:0]   divisor,
	output logic                            done,
	output logic [fspa_pkg::NODE_W-1:0]     quot,
	output logic [fspa_pkg::STRIDE_W-1:0]   rem
);

	logic                              busy_q;
	logic                              done_q;
	logic [fspa_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [fspa_pkg::NODE_W-1:0]       quot_q;
	logic [fspa_pkg::STRIDE_W-1:0]     rem_q;
	logic [fspa_pkg::STRIDE_W+1:0]     trial;
	logic                              borrow;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial  = {1'b0, rem_q, quot_q[fspa_pkg::NODE_W-1]} - {2'b00, divisor};
		borrow = trial[fspa_pkg::STRIDE_W+1];
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= fspa_pkg::DIV_CNT_W'(fspa_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == fspa_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= borrow ? {rem_q[fspa_pkg::STRIDE_W-2:0], quot_q[fspa_pkg::NODE_W-1]}
				: trial[fspa_pkg::STRIDE_W-1:0];
			quot_q <= {quot_q[fspa_pkg::NODE_W-2:0], ~borrow};
		end
	end

endmodule
`default_nettype wire

// File: sv/fspa_back.sv
`default_nettype none
module fspa_back #(
	parameter int SLOTS        = 1024,
	parameter int HEADER_BYTES = 24
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  fspa_pkg::cfg_t                 cfg,
	input  wire                            q_valid,
	output logic                           q_ready,
	input  fspa_pkg::req_t                 q_req,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [2:0]                     status,
	output logic [fspa_pkg::OUT_W-1:0]     slot_index_out,
	output logic [fspa_pkg::OUT_W-1:0]     data_offset_out
);

	localparam int IW = $clog2(SLOTS);
	localparam int MW = IW + 2;

	fspa_pkg::state_t                  state_q;
	fspa_pkg::op_t                     cur_op_q;
	fspa_pkg::status_t                 out_status_q;
	logic                              out_valid_q;
	logic [fspa_pkg::OUT_W-1:0]        out_idx_q;
	logic [fspa_pkg::OUT_W-1:0]        out_off_q;
	logic                              initialized_q;
	logic [fspa_pkg::CAP_W-1:0]        active_capacity_q;
	logic [fspa_pkg::STRIDE_W-1:0]     active_stride_q;
	logic [IW-1:0]                     free_top_q;
	logic                              free_empty_q;
	logic [fspa_pkg::CAP_W-1:0]        fresh_next_q;
	logic [IW-1:0]                     slot_q;
	logic [fspa_pkg::CAP_W-1:0]        mul_a_q;
	logic [fspa_pkg::PROD_W-1:0]       prod_q;

	// word: allocated flag, link empty, link
	logic [MW-1:0]                     mem_q [SLOTS];
	logic [MW-1:0]                     mem_rdata_q;
	logic                              mem_we;
	logic [IW-1:0]                     mem_waddr;
	logic [MW-1:0]                     mem_wdata;
	logic [IW-1:0]                     mem_raddr;

	logic                              pop;
	logic                              cfg_bad;
	logic                              fresh_avail;
	logic                              fresh_write;
	logic                              rd_alloc;
	logic                              rd_free;
	logic                              free_ok;
	logic                              div_start;
	logic                              div_done;
	logic [fspa_pkg::NODE_W-1:0]       div_quot;
	logic [fspa_pkg::STRIDE_W-1:0]     div_rem;

	fspa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_req.node),
		.divisor  (active_stride_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_comb begin
		q_ready     = (state_q == fspa_pkg::S_IDLE) && !out_valid_q;
		pop         = q_ready && q_valid;
		cfg_bad     = (cfg.capacity == '0) || (cfg.object_bytes == '0)
			|| (32'(cfg.capacity) > 32'(SLOTS));
		fresh_avail = fresh_next_q < active_capacity_q;
		fresh_write = pop && initialized_q && (q_req.op == fspa_pkg::OP_ALLOC)
			&& free_empty_q && fresh_avail;
		div_start   = pop && initialized_q && !q_req.node_neg
			&& (q_req.op inside {fspa_pkg::OP_FREE, fspa_pkg::OP_INDEX_OF});
		rd_alloc    = (state_q == fspa_pkg::S_RD) && (cur_op_q == fspa_pkg::OP_ALLOC);
		rd_free     = (state_q == fspa_pkg::S_RD) && (cur_op_q == fspa_pkg::OP_FREE);
		// slots at or above the fresh mark were never handed out since the last clear
		free_ok     = (32'(slot_q) < 32'(fresh_next_q)) && mem_rdata_q[MW-1];
		mem_we      = fresh_write || rd_alloc || (rd_free && free_ok);
		mem_waddr   = (state_q == fspa_pkg::S_RD) ? slot_q : IW'(fresh_next_q);
		mem_wdata   = {!rd_free, free_empty_q, free_top_q};
		mem_raddr   = (state_q == fspa_pkg::S_IDLE) ? free_top_q : IW'(div_quot);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem_q[mem_raddr];
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign slot_index_out  = out_idx_q;
	assign data_offset_out = out_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= fspa_pkg::S_IDLE;
			cur_op_q          <= fspa_pkg::OP_NOP;
			out_status_q      <= fspa_pkg::ST_OK;
			out_valid_q       <= 1'b0;
			out_idx_q         <= '0;
			out_off_q         <= '0;
			initialized_q     <= 1'b0;
			active_capacity_q <= '0;
			active_stride_q   <= '0;
			free_top_q        <= '0;
			free_empty_q      <= 1'b1;
			fresh_next_q      <= '0;
			slot_q            <= '0;
			mul_a_q           <= '0;
			prod_q            <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				fspa_pkg::S_IDLE: begin
					if (pop) begin
						cur_op_q     <= q_req.op;
						out_status_q <= fspa_pkg::ST_OK;
						out_idx_q    <= '0;
						out_off_q    <= '0;
						slot_q       <= free_top_q;
						mul_a_q      <= fspa_pkg::CAP_W'(free_top_q);
						case (q_req.op)
							fspa_pkg::OP_INIT: begin
								out_valid_q <= 1'b1;
								if (cfg_bad) begin
									out_status_q <= fspa_pkg::ST_INVALID_INIT;
								end else if (initialized_q) begin
									out_status_q <= fspa_pkg::ST_ALREADY_INIT;
								end else begin
									initialized_q     <= 1'b1;
									active_capacity_q <= cfg.capacity;
									active_stride_q   <= fspa_pkg::STRIDE_W'(HEADER_BYTES)
										+ fspa_pkg::STRIDE_W'(cfg.object_bytes);
									free_empty_q      <= 1'b1;
									fresh_next_q      <= '0;
								end
							end
							fspa_pkg::OP_DISABLE: begin
								out_valid_q <= 1'b1;
								if (!initialized_q) begin
									out_status_q <= fspa_pkg::ST_NOT_INIT;
								end else begin
									initialized_q     <= 1'b0;
									active_capacity_q <= '0;
									active_stride_q   <= '0;
									free_empty_q      <= 1'b1;
									fresh_next_q      <= '0;
								end
							end
							fspa_pkg::OP_ALLOC: begin
								if (!initialized_q) begin
									out_valid_q  <= 1'b1;
									out_status_q <= fspa_pkg::ST_NOT_INIT;
								end else if (!free_empty_q) begin
									state_q <= fspa_pkg::S_RD;
								end else if (fresh_avail) begin
									slot_q       <= IW'(fresh_next_q);
									mul_a_q      <= fresh_next_q;
									fresh_next_q <= fresh_next_q + 1'b1;
									state_q      <= fspa_pkg::S_MUL;
								end else begin
									out_valid_q  <= 1'b1;
									out_status_q <= fspa_pkg::ST_EMPTY;
								end
							end
							fspa_pkg::OP_FREE, fspa_pkg::OP_INDEX_OF: begin
								if (!initialized_q) begin
									out_valid_q  <= 1'b1;
									out_status_q <= fspa_pkg::ST_NOT_INIT;
								end else if (q_req.node_neg) begin
									out_valid_q  <= 1'b1;
									out_status_q <= fspa_pkg::ST_BAD_OFFSET;
								end else begin
									state_q <= fspa_pkg::S_DIV;
								end
							end
							fspa_pkg::OP_OFFSET_OF: begin
								if (!initialized_q) begin
									out_valid_q  <= 1'b1;
									out_status_q <= fspa_pkg::ST_NOT_INIT;
								end else if (q_req.slot_index >= active_capacity_q) begin
									out_valid_q  <= 1'b1;
									out_status_q <= fspa_pkg::ST_RANGE;
								end else begin
									mul_a_q <= q_req.slot_index;
									state_q <= fspa_pkg::S_MUL;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				fspa_pkg::S_DIV: begin
					if (div_done) begin
						if (div_rem != '0) begin
							out_valid_q  <= 1'b1;
							out_status_q <= fspa_pkg::ST_BAD_OFFSET;
							state_q      <= fspa_pkg::S_IDLE;
						end else if (cur_op_q == fspa_pkg::OP_INDEX_OF) begin
							out_valid_q <= 1'b1;
							out_idx_q   <= div_quot;
							state_q     <= fspa_pkg::S_IDLE;
						end else if (div_quot >= fspa_pkg::NODE_W'(active_capacity_q)) begin
							out_valid_q  <= 1'b1;
							out_status_q <= fspa_pkg::ST_RANGE;
							state_q      <= fspa_pkg::S_IDLE;
						end else begin
							slot_q  <= IW'(div_quot);
							state_q <= fspa_pkg::S_RD;
						end
					end
				end
				fspa_pkg::S_RD: begin
					if (cur_op_q == fspa_pkg::OP_ALLOC) begin
						free_top_q   <= mem_rdata_q[IW-1:0];
						free_empty_q <= mem_rdata_q[IW];
						state_q      <= fspa_pkg::S_MUL;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= fspa_pkg::S_IDLE;
						if (!free_ok) begin
							out_status_q <= fspa_pkg::ST_NOT_ALLOC;
						end else begin
							free_top_q   <= slot_q;
							free_empty_q <= 1'b0;
						end
					end
				end
				fspa_pkg::S_MUL: begin
					prod_q  <= fspa_pkg::PROD_W'(mul_a_q) * fspa_pkg::PROD_W'(active_stride_q);
					state_q <= fspa_pkg::S_FIN;
				end
				fspa_pkg::S_FIN: begin
					out_valid_q <= 1'b1;
					out_off_q   <= fspa_pkg::OUT_W'(prod_q + fspa_pkg::PROD_W'(HEADER_BYTES));
					if (cur_op_q == fspa_pkg::OP_ALLOC) begin
						out_idx_q <= fspa_pkg::OUT_W'(slot_q);
					end
					state_q <= fspa_pkg::S_IDLE;
				end
				default: begin
					state_q <= fspa_pkg::S_IDLE;
				end
			endcase
		end
	end

	a_out_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == fspa_pkg::S_IDLE))
		else $error("result pending while sequencer busy");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_next_q <= active_capacity_q)
		else $error("fresh mark above capacity");

	a_clear_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		!initialized_q |-> (free_empty_q && (fresh_next_q == '0)))
		else $error("pool state left over while not initialized");

	a_write_needs_init: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> initialized_q)
		else $error("slot store written while not initialized");

	a_div_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == fspa_pkg::S_DIV))
		else $error("divider started outside divide step");

endmodule
`default_nettype wire

// File: sv/fixed_slot_pool_allocator_core.sv
`default_nettype none
// Fixed-size slot pool allocator. Requests pass through a front register and a two-entry
// queue, so the input keeps taking requests, until the queue fills, while the back end
// works and a result waits in the output register. The back end runs one request at a
// time: init, disable and checks that fail on arrival finish straight from idle; alloc
// goes through multiply and finish, after a slot-store read when it pops the free stack;
// offset_of goes through multiply and finish; free and index_of wait on the 27-step
// bit-serial divider, which checks offset against stride; free adds a slot-store read.
// Allocation state uses a fresh-slot mark, so reset and disable need no clearing pass.
module fixed_slot_pool_allocator_core #(
	parameter int SLOTS        = 1024,
	parameter int HEADER_BYTES = 24
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_write,
	input  wire  [fspa_pkg::REG_IDX_W-1:0]      cfg_index,
	input  wire  [fspa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [fspa_pkg::CMD_W-1:0]          command,
	input  wire  signed [fspa_pkg::OFF_W-1:0]   data_offset,
	input  wire  [fspa_pkg::CAP_W-1:0]          slot_index,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [2:0]                          status,
	output logic [fspa_pkg::OUT_W-1:0]          slot_index_out,
	output logic [fspa_pkg::OUT_W-1:0]          data_offset_out
);

	fspa_pkg::cfg_t cfg_q;
	fspa_pkg::req_t front_req;
	fspa_pkg::req_t queue_req;
	logic           front_valid;
	logic           front_ready;
	logic           queue_valid;
	logic           queue_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				fspa_pkg::REG_CAPACITY:     cfg_q.capacity <= cfg_data[fspa_pkg::CAP_W-1:0];
				fspa_pkg::REG_OBJECT_BYTES: cfg_q.object_bytes <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fspa_front #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.data_offset (data_offset),
		.slot_index  (slot_index),
		.push_valid  (front_valid),
		.push_ready  (front_ready),
		.push_req    (front_req)
	);

	fspa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_req   (front_req),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_req    (queue_req)
	);

	fspa_back #(
		.SLOTS        (SLOTS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_valid         (queue_valid),
		.q_ready         (queue_ready),
		.q_req           (queue_req),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.slot_index_out  (slot_index_out),
		.data_offset_out (data_offset_out)
	);

endmodule
`default_nettype wire

// File: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 1024;
	localparam int HDR = 24;
	localparam logic [fspa_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [fspa_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

	typedef struct {
		logic [fspa_pkg::CMD_W-1:0]        cmd;
		logic signed [fspa_pkg::OFF_W-1:0] offset;
		logic [fspa_pkg::CAP_W-1:0]        index;
	} pool_cmd_t;

	typedef struct {
		fspa_pkg::status_t          st;
		logic [fspa_pkg::OUT_W-1:0] idx;
		logic [fspa_pkg::OUT_W-1:0] off;
	} pool_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [fspa_pkg::REG_IDX_W-1:0] cfg_index = fspa_pkg::REG_CAPACITY;
	logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [fspa_pkg::CMD_W-1:0] command = fspa_pkg::CMD_ALLOC;
	logic signed [fspa_pkg::OFF_W-1:0] data_offset = '0;
	logic [fspa_pkg::CAP_W-1:0] slot_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [fspa_pkg::OUT_W-1:0] slot_index_out;
	logic [fspa_pkg::OUT_W-1:0] data_offset_out;

	fixed_slot_pool_allocator_core #(
		.SLOTS(SLOTS),
		.HEADER_BYTES(HDR)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.data_offset(data_offset),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.slot_index_out(slot_index_out),
		.data_offset_out(data_offset_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pool shadow state
	logic [fspa_pkg::CAP_W-1:0] link_mem [SLOTS];
	bit taken [SLOTS];
	logic [fspa_pkg::CAP_W-1:0] stack_top;
	logic [fspa_pkg::CAP_W-1:0] fresh_mark;
	bit pool_on;
	logic [fspa_pkg::CAP_W-1:0] pool_cap;
	logic [fspa_pkg::STRIDE_W-1:0] pool_stride;
	logic [fspa_pkg::CAP_W-1:0] reg_capacity = '0;
	logic [fspa_pkg::OBJ_W-1:0] reg_obj = '0;

	pool_cmd_t pool_cmds [$];
	pool_reply_t awaited_replies [$];
	pool_cmd_t cur_cmd;
	int cmds_taken = 0;
	int replies_seen = 0;
	int fails = 0;
	int settings_used = 0;
	int rx_hold = 0;

	function automatic void clear_pool();
		for (int i = 0; i < SLOTS; i++) begin
			taken[i] = 1'b0;
			link_mem[i] = '0;
		end
		stack_top = fspa_pkg::CAP_W'(SLOTS);
		fresh_mark = '0;
		pool_on = 1'b0;
		pool_cap = '0;
		pool_stride = '0;
	endfunction

	function automatic fspa_pkg::status_t locate_slot(
			input logic signed [fspa_pkg::OFF_W-1:0] off, output longint idx);
		longint node;
		longint strd;
		node = off;
		node = node - HDR;
		strd = pool_stride;
		idx = 0;
		if (node < 0 || node % strd != 0)
			return fspa_pkg::ST_BAD_OFFSET;
		idx = node / strd;
		return fspa_pkg::ST_OK;
	endfunction

	function automatic pool_reply_t apply_pool_cmd(input pool_cmd_t c);
		pool_reply_t reply;
		longint idx;
		int slot;
		reply.st = fspa_pkg::ST_OK;
		reply.idx = '0;
		reply.off = '0;
		case (c.cmd)
			fspa_pkg::CMD_INIT: begin
				if (reg_capacity == 0 || reg_obj == 0 || reg_capacity > SLOTS) begin
					reply.st = fspa_pkg::ST_INVALID_INIT;
				end else if (pool_on) begin
					reply.st = fspa_pkg::ST_ALREADY_INIT;
				end else begin
					clear_pool();
					pool_cap = reg_capacity;
					pool_stride = fspa_pkg::STRIDE_W'(HDR) + reg_obj;
					pool_on = 1'b1;
				end
			end
			fspa_pkg::CMD_DISABLE: begin
				if (!pool_on)
					reply.st = fspa_pkg::ST_NOT_INIT;
				else
					clear_pool();
			end
			fspa_pkg::CMD_ALLOC: begin
				if (!pool_on) begin
					reply.st = fspa_pkg::ST_NOT_INIT;
				end else begin
					slot = -1;
					if (stack_top < SLOTS) begin
						slot = int'(stack_top);
						stack_top = link_mem[slot];
					end else if (fresh_mark < pool_cap) begin
						slot = int'(fresh_mark);
						fresh_mark = fresh_mark + 1'b1;
					end
					if (slot < 0) begin
						reply.st = fspa_pkg::ST_EMPTY;
					end else begin
						taken[slot] = 1'b1;
						reply.idx = fspa_pkg::OUT_W'(slot);
						reply.off = fspa_pkg::OUT_W'(longint'(slot) * longint'(pool_stride) + HDR);
					end
				end
			end
			fspa_pkg::CMD_FREE: begin
				if (!pool_on) begin
					reply.st = fspa_pkg::ST_NOT_INIT;
				end else begin
					reply.st = locate_slot(c.offset, idx);
					if (reply.st == fspa_pkg::ST_OK) begin
						if (idx >= longint'(pool_cap)) begin
							reply.st = fspa_pkg::ST_RANGE;
						end else if (!taken[idx]) begin
							reply.st = fspa_pkg::ST_NOT_ALLOC;
						end else begin
							taken[idx] = 1'b0;
							link_mem[idx] = stack_top;
							stack_top = fspa_pkg::CAP_W'(idx);
						end
					end
				end
			end
			fspa_pkg::CMD_INDEX_OF: begin
				if (!pool_on) begin
					reply.st = fspa_pkg::ST_NOT_INIT;
				end else begin
					reply.st = locate_slot(c.offset, idx);
					if (reply.st == fspa_pkg::ST_OK)
						reply.idx = fspa_pkg::OUT_W'(idx);
				end
			end
			fspa_pkg::CMD_OFFSET_OF: begin
				if (!pool_on)
					reply.st = fspa_pkg::ST_NOT_INIT;
				else if (c.index >= pool_cap)
					reply.st = fspa_pkg::ST_RANGE;
				else
					reply.off = fspa_pkg::OUT_W'(longint'(c.index) * longint'(pool_stride) + HDR);
			end
			default: begin
			end
		endcase
		return reply;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				awaited_replies.push_back(apply_pool_cmd(cur_cmd));
				cmds_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pool_cmds.size() != 0 && ((cmds_taken >= 150 && cmds_taken < 230) ||
						$urandom_range(99) >= 30)) begin
					cur_cmd = pool_cmds.pop_front();
					in_valid <= 1'b1;
					command <= cur_cmd.cmd;
					data_offset <= cur_cmd.offset;
					slot_index <= cur_cmd.index;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// reply monitor
	always @(posedge clk) begin : rx
		pool_reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				replies_seen++;
				if (awaited_replies.size() == 0) begin
					$error("reply with nothing outstanding: status %0d", status);
					fails++;
				end else begin
					want = awaited_replies.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						fails++;
					end
					if (slot_index_out !== want.idx) begin
						$error("slot_index_out: expected %0d, actual %0d", want.idx,
							slot_index_out);
						fails++;
					end
					if (data_offset_out !== want.off) begin
						$error("data_offset_out: expected %0d, actual %0d", want.off,
							data_offset_out);
						fails++;
					end
				end
				if (replies_seen == 60 || replies_seen == 260)
					rx_hold = 300;
			end
			if (rx_hold != 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (replies_seen >= 150 && replies_seen < 230) ||
					$urandom_range(99) >= 30;
			end
		end
	end

	task automatic put(input logic [fspa_pkg::CMD_W-1:0] cmd, input logic [31:0] off,
			input logic [31:0] idx);
		pool_cmd_t c;
		c.cmd = cmd;
		c.offset = fspa_pkg::OFF_W'(off);
		c.index = fspa_pkg::CAP_W'(idx);
		pool_cmds.push_back(c);
	endtask

	function automatic logic [31:0] slot_off(input longint idx, input longint strd);
		return 32'(idx * strd + HDR);
	endfunction

	task automatic settle();
		do
			@(negedge clk);
		while (pool_cmds.size() != 0 || in_valid || awaited_replies.size() != 0);
	endtask

	task automatic set_regs(input logic [fspa_pkg::CAP_W-1:0] cap,
			input logic [fspa_pkg::OBJ_W-1:0] obj);
		settle();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= fspa_pkg::REG_CAPACITY;
		cfg_data <= {5'($urandom), cap};
		@(posedge clk);
		cfg_index <= fspa_pkg::REG_OBJECT_BYTES;
		cfg_data <= obj;
		@(posedge clk);
		cfg_write <= 1'b0;
		reg_capacity = cap;
		reg_obj = obj;
		settings_used++;
	endtask

	task automatic random_phase(input logic [fspa_pkg::CAP_W-1:0] cap,
			input logic [fspa_pkg::OBJ_W-1:0] obj, input int n);
		longint strd;
		int lim;
		int top;
		int r;
		set_regs(cap, obj);
		strd = HDR + obj;
		lim = (cap < 12) ? cap : 12;
		top = int'((134217727 - HDR) / strd);
		top = (top > 4000) ? 4000 : top;
		put(fspa_pkg::CMD_INIT, $urandom, $urandom);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 35) begin
				put(fspa_pkg::CMD_ALLOC, $urandom, $urandom);
			end else if (r < 60) begin
				put(fspa_pkg::CMD_FREE, slot_off($urandom_range(lim), strd), $urandom);
			end else if (r < 70) begin
				put(fspa_pkg::CMD_INDEX_OF, slot_off($urandom_range(top), strd), $urandom);
			end else if (r < 78) begin
				put(fspa_pkg::CMD_OFFSET_OF, $urandom, $urandom_range(cap + 2));
			end else if (r < 84) begin
				put((r & 1) ? fspa_pkg::CMD_FREE : fspa_pkg::CMD_INDEX_OF, $urandom, $urandom);
			end else if (r < 87) begin
				put((r & 1) ? fspa_pkg::CMD_FREE : fspa_pkg::CMD_INDEX_OF,
					slot_off($urandom_range(lim), strd) + $urandom_range(1, 32'(strd - 1)),
					$urandom);
			end else if (r < 90) begin
				put((r & 1) ? fspa_pkg::CMD_FREE : fspa_pkg::CMD_INDEX_OF,
					$urandom_range(HDR - 1), $urandom);
			end else if (r < 93) begin
				put(fspa_pkg::CMD_OFFSET_OF, $urandom, $urandom);
			end else if (r < 95) begin
				put(fspa_pkg::CMD_INIT, $urandom, $urandom);
			end else if (r < 97) begin
				put(fspa_pkg::CMD_DISABLE, $urandom, $urandom);
				put(fspa_pkg::CMD_INIT, $urandom, $urandom);
			end else begin
				put((r & 1) ? CMD_SPARE_B : CMD_SPARE_A, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		longint big;
		clear_pool();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing set up yet
		put(fspa_pkg::CMD_ALLOC, $urandom, $urandom);
		put(fspa_pkg::CMD_FREE, HDR, $urandom);
		put(fspa_pkg::CMD_INDEX_OF, HDR, $urandom);
		put(fspa_pkg::CMD_OFFSET_OF, $urandom, '0);
		put(fspa_pkg::CMD_DISABLE, $urandom, $urandom);
		put(fspa_pkg::CMD_INIT, $urandom, $urandom);
		put(CMD_SPARE_A, $urandom, $urandom);

		// bad register settings
		set_regs(11'd2047, 16'd1);
		put(fspa_pkg::CMD_INIT, $urandom, $urandom);
		set_regs(11'd1025, 16'd1);
		put(fspa_pkg::CMD_INIT, $urandom, $urandom);
		set_regs(11'd4, 16'd0);
		put(fspa_pkg::CMD_INIT, $urandom, $urandom);

		// widest stride, two slots
		set_regs(11'd2, 16'hFFFF);
		big = HDR + 16'hFFFF;
		put(fspa_pkg::CMD_INIT, $urandom, $urandom);
		put(fspa_pkg::CMD_INIT, $urandom, $urandom);
		put(fspa_pkg::CMD_ALLOC, $urandom, $urandom);
		put(fspa_pkg::CMD_ALLOC, $urandom, $urandom);
		put(fspa_pkg::CMD_ALLOC, $urandom, $urandom);
		put(fspa_pkg::CMD_FREE, slot_off(1, big), $urandom);
		put(fspa_pkg::CMD_FREE, slot_off(1, big), $urandom);
		put(fspa_pkg::CMD_FREE, HDR - 1, $urandom);
		put(fspa_pkg::CMD_FREE, 32'h8000000, $urandom);
		put(fspa_pkg::CMD_FREE, slot_off(0, big) + 1, $urandom);
		put(fspa_pkg::CMD_FREE, slot_off(2, big), $urandom);
		put(fspa_pkg::CMD_INDEX_OF, slot_off(5, big), $urandom);
		put(fspa_pkg::CMD_OFFSET_OF, $urandom, 32'd2047);
		put(fspa_pkg::CMD_OFFSET_OF, $urandom, 32'd1);
		put(fspa_pkg::CMD_ALLOC, $urandom, $urandom);
		put(fspa_pkg::CMD_DISABLE, $urandom, $urandom);
		put(fspa_pkg::CMD_ALLOC, $urandom, $urandom);

		random_phase(11'd8, 16'd8, 70);
		random_phase(11'd1, 16'd1, 50);
		random_phase(11'd1024, 16'hFFFF, 70);
		random_phase(11'd16, fspa_pkg::OBJ_W'($urandom_range(1, 65535)), 70);
		random_phase(11'd5, 16'd3, 60);
		random_phase(11'd1024, 16'd1, 60);

		settle();
		repeat (40) @(posedge clk);
		$display("ran %0d requests under %0d register settings, %0d replies checked",
			cmds_taken, settings_used, replies_seen);
		$display("mix of init, disable, alloc, free, index_of, offset_of with stalls");
		if (fails == 0 && awaited_replies.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
sv/fspa_pkg.sv
sv/fspa_front.sv
sv/fspa_queue.sv
sv/fspa_div.sv
sv/fspa_back.sv
sv/fixed_slot_pool_allocator_core.sv
test/tb.sv
